// ===== rtl/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the input shaper convolver: field widths,
// register indexes and the control word that travels with each tap read.
// ----------------------------------------------------------------------------
package isc_pkg;

   // Default geometry
   localparam int DEPTH_DEF = 256;
   localparam int TAPS_DEF  = 4;

   // Fixed field widths
   localparam int MAX_TAPS   = 4;
   localparam int TAP_IDX_W  = 2;
   localparam int SAMPLE_W   = 16;
   localparam int AMP_W      = 16;
   localparam int LAG_W      = 8;
   localparam int LAG_RANGE  = 1 << LAG_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Arithmetic: Q2.14 amplitudes, 32-bit products, 34-bit sum of four
   localparam int QBITS    = 14;
   localparam int HALF_LSB = 1 << (QBITS - 1);
   localparam int PROD_W   = SAMPLE_W + AMP_W;
   localparam int ACC_W    = PROD_W + TAP_IDX_W;

   typedef logic signed [AMP_W-1:0] amp_type;

   localparam amp_type AMP_FIRST_RESET = amp_type'(16384);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMP_FIRST  = 3'd0,
      CSR_AMP_SECOND = 3'd1,
      CSR_AMP_THIRD  = 3'd2,
      CSR_AMP_FOURTH = 3'd3,
      CSR_LAG_FIRST  = 3'd4,
      CSR_LAG_SECOND = 3'd5,
      CSR_LAG_THIRD  = 3'd6,
      CSR_LAG_FOURTH = 3'd7
   } csr_idx_type;

   // Control word aligned with one delay-line read
   typedef struct packed {
      logic                 vld;
      logic                 keep;   // entry has been written since reset
      logic                 first;
      logic                 last;
      logic [TAP_IDX_W-1:0] tap;
   } tap_ctl_type;

endpackage

// ===== rtl/isc_delay_line.sv =====
// ----------------------------------------------------------------------------
// isc_delay_line
// Circular sample memory: one write port, one read port, registered read
// data. A read and a write to the same entry in one cycle return old data.
// ----------------------------------------------------------------------------
module isc_delay_line import isc_pkg::*; #(
   parameter  int DEPTH = DEPTH_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                adv,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // Store the incoming sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one tap per cycle; hold while the pipeline is frozen
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/isc_tap_seq.sv =====
// ----------------------------------------------------------------------------
// isc_tap_seq
// Tap sequencer: takes a transaction, writes its sample into the delay line
// and then issues one read per tap. Tracks the write slot and whether the
// delay line has wrapped, so entries never written read as zero.
// ----------------------------------------------------------------------------
module isc_tap_seq import isc_pkg::*; #(
   parameter  int DEPTH = DEPTH_DEF,
   parameter  int TAPS  = TAPS_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [AW-1:0] lag [MAX_TAPS],
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [AW-1:0] rd_addr,
   output tap_ctl_type   rd_ctl
);

   localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAPS - 1);
   localparam logic [AW-1:0]        TOP_SLOT = AW'(DEPTH - 1);
   localparam logic [AW-1:0]        DEPTH_AW = AW'(DEPTH);

   logic                 busy_ff;
   logic [TAP_IDX_W-1:0] tap_ff;
   logic [AW-1:0]        cur_slot_ff;
   logic [AW-1:0]        wr_slot_ff;
   logic                 wrapped_ff;
   tap_ctl_type          ctl_ff;
   tap_ctl_type          ctl_in;

   logic          ready;
   logic          accept;
   logic          issue;
   logic          is_last;
   logic [AW:0]   diff;
   logic          borrow;

   // Free for a new transaction when idle or issuing the last tap
   assign is_last   = (tap_ff == LAST_TAP);
   assign ready     = !busy_ff || is_last;
   assign accept    = req_valid && ready && adv;
   assign req_stall = !(ready && adv);
   assign issue     = busy_ff && adv;

   // Write the sample at the current slot on acceptance
   assign wr_en   = accept;
   assign wr_addr = wr_slot_ff;

   // Form the circular read address: slot minus lag, wrapped at depth
   assign diff    = {1'b0, cur_slot_ff} - {1'b0, lag[tap_ff]};
   assign borrow  = diff[AW];
   assign rd_addr = borrow ? (diff[AW-1:0] + DEPTH_AW) : diff[AW-1:0];

   always_comb begin
      ctl_in.vld   = issue;
      ctl_in.keep  = wrapped_ff || !borrow;
      ctl_in.first = (tap_ff == '0);
      ctl_in.last  = is_last;
      ctl_in.tap   = tap_ff;
   end

   // Advance slot, fill state and tap counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         tap_ff      <= '0;
         wr_slot_ff  <= '0;
         wrapped_ff  <= 1'b0;
         ctl_ff.vld  <= 1'b0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
         if (accept) begin
            busy_ff     <= 1'b1;
            tap_ff      <= '0;
            cur_slot_ff <= wr_slot_ff;
            if (wr_slot_ff == TOP_SLOT) begin
               wr_slot_ff <= '0;
               wrapped_ff <= 1'b1;
            end else begin
               wr_slot_ff <= wr_slot_ff + 1'b1;
            end
         end else if (issue) begin
            if (is_last) begin
               busy_ff <= 1'b0;
            end else begin
               tap_ff <= tap_ff + 1'b1;
            end
         end
      end
   end

   assign rd_ctl = ctl_ff;

endmodule

// ===== rtl/isc_mac.sv =====
// ----------------------------------------------------------------------------
// isc_mac
// Multiply each tap read by its amplitude, accumulate over the taps of one
// transaction, round to nearest, saturate and hold the result for output.
// ----------------------------------------------------------------------------
module isc_mac import isc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  tap_ctl_type                rd_ctl,
   input  logic [SAMPLE_W-1:0]        rd_data,
   input  amp_type                    amp [MAX_TAPS],
   input  logic                       rsp_stall,
   output logic                       adv,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_shaped_sample,
   output logic                       rsp_clipped
);

   localparam int RND_W = ACC_W - QBITS;
   localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(32767);
   localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(-32768);
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF_LSB);

   logic signed [SAMPLE_W-1:0] data_eff;
   amp_type                    amp_sel;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       p_vld_ff;
   logic                       p_first_ff;
   logic                       p_last_ff;
   logic signed [ACC_W-1:0]    acc_base;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       done_ff;
   logic signed [ACC_W-1:0]    biased;
   logic signed [RND_W-1:0]    rounded;
   logic signed [SAMPLE_W-1:0] sat_in;
   logic                       clip_in;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_clip_ff;

   // Freeze everything while a finished sum cannot move into a held output
   assign adv = !(done_ff && rsp_valid_ff && rsp_stall);

   // Product stage: drop entries never written
   assign data_eff = rd_ctl.keep ? $signed(rd_data) : '0;
   assign amp_sel  = amp[rd_ctl.tap];
   assign prod_in  = amp_sel * data_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= rd_ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         p_first_ff <= rd_ctl.first;
         p_last_ff  <= rd_ctl.last;
      end
   end

   // Accumulate stage: restart on the first tap
   always_comb begin
      if (p_first_ff) begin
         acc_base = '0;
      end else begin
         acc_base = acc_ff;
      end
      acc_in = acc_base + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (adv) begin
         done_ff <= p_vld_ff && p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && p_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Round half up, then saturate to 16 bits
   always_comb begin
      biased  = acc_ff + ACC_HALF;
      rounded = biased[ACC_W-1:QBITS];
      clip_in = 1'b0;
      sat_in  = rounded[SAMPLE_W-1:0];
      if (rounded > RND_MAX) begin
         sat_in  = RND_MAX[SAMPLE_W-1:0];
         clip_in = 1'b1;
      end else if (rounded < RND_MIN) begin
         sat_in  = RND_MIN[SAMPLE_W-1:0];
         clip_in = 1'b1;
      end
   end

   // Output register: load a finished sum, drop the valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ff && adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_ff && adv) begin
         rsp_sample_ff <= sat_in;
         rsp_clip_ff   <= clip_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_shaped_sample = rsp_sample_ff;
   assign rsp_clipped       = rsp_clip_ff;

endmodule

// ===== rtl/input_shaper_convolver.sv =====
// ----------------------------------------------------------------------------
// input_shaper_convolver
// Input shaper: each sample enters a circular delay line and the result is
// the rounded, saturated sum of up to four amplitude-weighted delayed samples.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_ref_sample
//   rsp_      out        rsp_valid / rsp_stall  rsp_shaped_sample, rsp_clipped
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// The taps are read one per cycle, while the pipeline is not frozen, through
// the single read port of the delay-line memory. The next transaction is
// taken in the cycle its predecessor issues its last tap. Each tap read passes
// through the read, product and accumulate registers into the output register.
// Reset is synchronous. The delay line is not cleared: the write slot and a
// wrapped flag mark entries never written, and those read as zero.
// A held result with rsp_stall high lets the pipeline run on until the next
// sum is complete, then freezes it and stalls the request side.
// ----------------------------------------------------------------------------
module input_shaper_convolver import isc_pkg::*; #(
   parameter  int DEPTH = DEPTH_DEF,
   parameter  int TAPS  = TAPS_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_ref_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_shaped_sample,
   output logic                         rsp_clipped,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   amp_type       amp_ff [MAX_TAPS];
   amp_type       amp_in [MAX_TAPS];
   logic [AW-1:0] lag_ff [MAX_TAPS];
   logic [AW-1:0] lag_in [MAX_TAPS];
   logic [AW-1:0] lag_mod [LAG_RANGE];

   logic                adv;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   tap_ctl_type         rd_ctl;

   // Reduce each possible lag modulo the delay-line depth
   for (genvar g = 0; g < LAG_RANGE; g++) begin : g_lag_mod
      assign lag_mod[g] = AW'(g % DEPTH);
   end

   // Decode register writes
   always_comb begin
      amp_in = amp_ff;
      lag_in = lag_ff;
      if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_AMP_FIRST:  amp_in[0] = amp_type'(csr_wdata);
            CSR_AMP_SECOND: amp_in[1] = amp_type'(csr_wdata);
            CSR_AMP_THIRD:  amp_in[2] = amp_type'(csr_wdata);
            CSR_AMP_FOURTH: amp_in[3] = amp_type'(csr_wdata);
            CSR_LAG_FIRST:  lag_in[0] = lag_mod[csr_wdata[LAG_W-1:0]];
            CSR_LAG_SECOND: lag_in[1] = lag_mod[csr_wdata[LAG_W-1:0]];
            CSR_LAG_THIRD:  lag_in[2] = lag_mod[csr_wdata[LAG_W-1:0]];
            CSR_LAG_FOURTH: lag_in[3] = lag_mod[csr_wdata[LAG_W-1:0]];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= '{AMP_FIRST_RESET, '0, '0, '0};
         lag_ff <= '{'0, '0, '0, '0};
      end else begin
         amp_ff <= amp_in;
         lag_ff <= lag_in;
      end
   end

   isc_tap_seq #(
      .DEPTH (DEPTH),
      .TAPS  (TAPS)
   ) u_tap_seq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .lag       (lag_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .rd_ctl    (rd_ctl)
   );

   isc_delay_line #(
      .DEPTH (DEPTH)
   ) u_delay_line (
      .clock   (clock),
      .adv     (adv),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ref_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   isc_mac u_mac (
      .clock             (clock),
      .reset             (reset),
      .rd_ctl            (rd_ctl),
      .rd_data           (rd_data),
      .amp               (amp_ff),
      .rsp_stall         (rsp_stall),
      .adv               (adv),
      .rsp_valid         (rsp_valid),
      .rsp_shaped_sample (rsp_shaped_sample),
      .rsp_clipped       (rsp_clipped)
   );

endmodule
